// ===== hdl/sorted_keyed_table_macros.svh =====
// Assertion macros used by the sorted keyed table controller.
`ifndef SORTED_KEYED_TABLE_MACROS_SVH
`define SORTED_KEYED_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define SKT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset
`define SKT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SKT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define SKT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/skt_pkg.sv =====
// Package: commands, status codes and payload types of the sorted keyed table.
package skt_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int WORD_W       = 32;
    localparam int CNT_OUT_W    = 7;

    // Request commands
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // One stored entry
    typedef struct packed {
        logic signed [WORD_W-1:0] key;
        logic signed [WORD_W-1:0] amount;
        logic        [WORD_W-1:0] price;
    } t_entry;

    // One request
    typedef struct packed {
        logic        [1:0]        cmd;
        logic signed [WORD_W-1:0] item_key;
        logic signed [WORD_W-1:0] item_amount;
        logic        [WORD_W-1:0] item_price_bits;
    } t_item;

    // One result
    typedef struct packed {
        logic        [1:0]           status;
        logic signed [WORD_W-1:0]    found_amount;
        logic        [WORD_W-1:0]    found_price_bits;
        logic        [CNT_OUT_W-1:0] entry_count;
    } t_result;

endpackage

// ===== hdl/skt_if.sv =====
// Interfaces: request channel and result channel with valid/ready handshake.
interface skt_item_if;
    import skt_pkg::*;
    logic                     valid;
    logic                     ready;
    logic        [1:0]        cmd;
    logic signed [WORD_W-1:0] item_key;
    logic signed [WORD_W-1:0] item_amount;
    logic        [WORD_W-1:0] item_price_bits;

    modport source (output valid, cmd, item_key, item_amount, item_price_bits,
                    input ready);
    modport sink   (input valid, cmd, item_key, item_amount, item_price_bits,
                    output ready);
endinterface

interface skt_res_if;
    import skt_pkg::*;
    logic                        valid;
    logic                        ready;
    logic        [1:0]           status;
    logic signed [WORD_W-1:0]    found_amount;
    logic        [WORD_W-1:0]    found_price_bits;
    logic        [CNT_OUT_W-1:0] entry_count;

    modport source (output valid, status, found_amount, found_price_bits, entry_count,
                    input ready);
    modport sink   (input valid, status, found_amount, found_price_bits, entry_count,
                    output ready);
endinterface

// ===== hdl/skt_mem.sv =====
// Entry memory: one write port, one read port with registered read data.
module skt_mem #(
    parameter int DEPTH = skt_pkg::DEF_CAPACITY,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  skt_pkg::t_entry  i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output skt_pkg::t_entry  o_rdata
);
    import skt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/skt_ctrl.sv =====
// Sequencer: scans the entry memory for the key, then shifts entries up or down for an insert or remove.
`include "sorted_keyed_table_macros.svh"
module skt_ctrl #(
    parameter int CAPACITY = skt_pkg::DEF_CAPACITY,
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  skt_pkg::t_item   i_req,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output skt_pkg::t_result o_res,
    output logic             o_mem_we,
    output logic [AW-1:0]    o_mem_waddr,
    output skt_pkg::t_entry  o_mem_wdata,
    output logic [AW-1:0]    o_mem_raddr,
    input  skt_pkg::t_entry  i_mem_rdata
);
    import skt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_INS  = 3'd2;
    localparam logic [2:0] S_REM  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]               r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_ptr, n_ptr;
    logic [CW-1:0]            r_pos, n_pos;
    logic [CW-1:0]            r_rd_addr, n_rd_addr;
    logic                     r_rd_v, n_rd_v;
    t_result                  r_res, n_res;
    logic [1:0]               r_cmd;
    logic signed [WORD_W-1:0] r_key;
    logic signed [WORD_W-1:0] r_amount;
    logic        [WORD_W-1:0] r_price;

    logic          rd_en;
    logic [CW-1:0] rd_idx;
    logic          we;
    logic [CW-1:0] waddr;
    t_entry        wdata;
    logic          found;
    logic          scan_done;
    logic          d_hit;
    logic [CW-1:0] d_pos;

    // Entry count as carried on the result
    function automatic logic [CNT_OUT_W-1:0] cnt_out(input logic [CW-1:0] c);
        logic [EW-1:0] ext;
        begin
            ext = EW'(c);
            return ext[CNT_OUT_W-1:0];
        end
    endfunction

    // Scan outcome from the entry read last cycle
    assign found     = r_rd_v && (i_mem_rdata.key >= r_key);
    assign scan_done = found || (r_ptr == r_count);
    assign d_pos     = found ? r_rd_addr : r_count;
    assign d_hit     = found && (i_mem_rdata.key == r_key);

    // Next-state logic
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_pos     = r_pos;
        n_rd_addr = r_rd_addr;
        n_rd_v    = 1'b0;
        n_res     = r_res;
        rd_en     = 1'b0;
        rd_idx    = r_ptr;
        we        = 1'b0;
        waddr     = r_rd_addr;
        wdata     = i_mem_rdata;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_ptr = '0;
                    if (i_req.cmd == CMD_NONE) begin
                        n_res   = '{ST_OK, '0, '0, cnt_out(r_count)};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_DONE;
                    unique case (r_cmd)
                        CMD_LOOKUP: begin
                            if (d_hit) begin
                                n_res = '{ST_OK, i_mem_rdata.amount, i_mem_rdata.price,
                                          cnt_out(r_count)};
                            end else begin
                                n_res = '{ST_NOT_FOUND, '0, '0, cnt_out(r_count)};
                            end
                        end
                        CMD_REMOVE: begin
                            if (!d_hit) begin
                                n_res = '{ST_NOT_FOUND, '0, '0, cnt_out(r_count)};
                            end else if (d_pos + 1'b1 == r_count) begin
                                n_count = r_count - 1'b1;
                                n_res   = '{ST_OK, '0, '0, cnt_out(r_count - 1'b1)};
                            end else begin
                                n_ptr   = d_pos + 1'b1;
                                n_state = S_REM;
                            end
                        end
                        CMD_INSERT: begin
                            if (d_hit) begin
                                n_res = '{ST_DUPLICATE, '0, '0, cnt_out(r_count)};
                            end else if (r_count == CAP_C) begin
                                n_res = '{ST_FULL, '0, '0, cnt_out(r_count)};
                            end else begin
                                n_ptr   = r_count;
                                n_pos   = d_pos;
                                n_state = S_INS;
                            end
                        end
                        default: begin
                            n_res = '{ST_OK, '0, '0, cnt_out(r_count)};
                        end
                    endcase
                end else begin
                    rd_en     = 1'b1;
                    rd_idx    = r_ptr;
                    n_rd_addr = r_ptr;
                    n_rd_v    = 1'b1;
                    n_ptr     = r_ptr + 1'b1;
                end
            end
            S_REM: begin
                // move entry read last cycle one place down
                if (r_rd_v) begin
                    we    = 1'b1;
                    waddr = r_rd_addr - 1'b1;
                end
                if (r_ptr != r_count) begin
                    rd_en     = 1'b1;
                    rd_idx    = r_ptr;
                    n_rd_addr = r_ptr;
                    n_rd_v    = 1'b1;
                    n_ptr     = r_ptr + 1'b1;
                end else begin
                    n_count = r_count - 1'b1;
                    n_res   = '{ST_OK, '0, '0, cnt_out(r_count - 1'b1)};
                    n_state = S_DONE;
                end
            end
            S_INS: begin
                // move entry read last cycle one place up
                if (r_rd_v) begin
                    we    = 1'b1;
                    waddr = r_rd_addr + 1'b1;
                end
                if (r_ptr != r_pos) begin
                    rd_en     = 1'b1;
                    rd_idx    = r_ptr - 1'b1;
                    n_rd_addr = r_ptr - 1'b1;
                    n_rd_v    = 1'b1;
                    n_ptr     = r_ptr - 1'b1;
                end else if (!r_rd_v) begin
                    we      = 1'b1;
                    waddr   = r_pos;
                    wdata   = '{r_key, r_amount, r_price};
                    n_count = r_count + 1'b1;
                    n_res   = '{ST_OK, '0, '0, cnt_out(r_count + 1'b1)};
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rd_v  <= n_rd_v;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_pos     <= n_pos;
        r_rd_addr <= n_rd_addr;
        r_res     <= n_res;
        if (i_req_valid && o_req_ready) begin
            r_cmd    <= i_req.cmd;
            r_key    <= i_req.item_key;
            r_amount <= i_req.item_amount;
            r_price  <= i_req.item_price_bits;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;
    assign o_mem_we    = we;
    assign o_mem_waddr = waddr[AW-1:0];
    assign o_mem_wdata = wdata;
    assign o_mem_raddr = rd_idx[AW-1:0];

    `SKT_ASSERT_NOW(a_cnt_max, i_clk, i_rst_n, 1'b1, r_count <= CAP_C, "count above capacity")
    `SKT_ASSERT_NOW(a_we_shift, i_clk, i_rst_n, we, (r_state == S_INS) || (r_state == S_REM), "memory write outside shift")
    `SKT_ASSERT_NEXT(a_cnt_hold, i_clk, i_rst_n, (r_state == S_IDLE) || (r_state == S_DONE), $stable(r_count), "count changed while idle")
    `SKT_ASSERT_NOW(a_scan_bound, i_clk, i_rst_n, (r_state == S_SCAN) && rd_en, r_ptr < r_count, "scan read past fill")
    `SKT_ASSERT_NOW(a_ins_room, i_clk, i_rst_n, r_state == S_INS, r_count < CAP_C, "insert shift into full table")

endmodule

// ===== hdl/sorted_keyed_table.sv =====
// Top level: sorted keyed table with request/result channels and output register.
//
//  channel  | dir | payload
//  ---------+-----+--------------------------------------------------------
//  i_item   | in  | cmd, item_key, item_amount, item_price_bits
//  o_res    | out | status, found_amount, found_price_bits, entry_count
//
// One request at a time: acceptance in the idle state, a key scan that stops at the first
// entry whose key is not below the request key (or runs past the last entry), an insert
// shift that moves the entries from there up one place or a remove shift that moves the
// later entries down one place, and a hand-off of the result to the output register.
// Reset clears the entry count; memory contents need no clearing. A new request is taken
// while a result waits in the output register; a finished request stalls until it drains.
module sorted_keyed_table #(
    parameter int CAPACITY = skt_pkg::DEF_CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    skt_item_if.sink   i_item,
    skt_res_if.source  o_res
);
    import skt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    t_item         req;
    logic          res_valid;
    logic          res_take;
    t_result       res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;
    logic          r_out_v;
    t_result       r_out;

    assign req = '{i_item.cmd, i_item.item_key, i_item.item_amount, i_item.item_price_bits};

    skt_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_item.valid),
        .o_req_ready (i_item.ready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_take),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    skt_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register: loads when empty or being drained
    assign res_take = !r_out_v || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_v <= 1'b1;
        end else if (o_res.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_out <= res;
        end
    end

    assign o_res.valid            = r_out_v;
    assign o_res.status           = r_out.status;
    assign o_res.found_amount     = r_out.found_amount;
    assign o_res.found_price_bits = r_out.found_price_bits;
    assign o_res.entry_count      = r_out.entry_count;

endmodule
